@@ src/stersu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stersu_pkg
// Shared field widths, codes and register indexes for the sorted table
// equal-range search unit.
// ----------------------------------------------------------------------------
package stersu_pkg;

   localparam int POS_W   = 10;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 10;
   localparam int CSR_IDX_W = 1;
   // index arithmetic range: holds -1 .. 2*1023
   localparam int IDX_W   = 12;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_FIRST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_LAST  = 1'b1;

   localparam logic [CSR_W-1:0] SEARCH_FIRST_RESET = 10'd0;
   localparam logic [CSR_W-1:0] SEARCH_LAST_RESET  = 10'd1023;

endpackage

@@ src/stersu_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stersu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stersu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sorted_table_equal_range_search_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_unit
// Write word: stores one table element. Query word: binary search
// over the configured index range, then an outward scan over equal entries.
// A query probes the midpoint (read, then compare) until a hit or an empty
// range, at most 11 probes over 1024 entries, then scans left and right one
// equal neighbor at a time through the single RAM read port. One word is in work
// at a time; a held result holds the next query in its last state. Reset is
// synchronous and clears control and the range registers; table contents are
// undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // query / write channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [stersu_pkg::POS_W-1:0]        req_position,
   input  logic signed [stersu_pkg::DATA_W-1:0] req_element_value,
   input  logic signed [stersu_pkg::DATA_W-1:0] req_search_key,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [stersu_pkg::POS_W-1:0]        rsp_first_position,
   output logic [stersu_pkg::POS_W-1:0]        rsp_last_position,
   output logic [stersu_pkg::COUNT_W-1:0]      rsp_match_count,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [stersu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stersu_pkg::CSR_W-1:0]        csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   // depth compare is done in 17 bits so it covers the whole depth range
   localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);
   localparam logic [16:0] MAX_IDX_V = 17'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROBE,   // issue read at mid, or finish as a miss
      S_PCMP,    // compare probe, narrow the range
      S_LEFT,    // issue read left of the run
      S_LCMP,
      S_RIGHT,   // issue read right of the run
      S_RCMP,
      S_OUT      // land the result in the output register
   } state_type;

   state_type state_ff, state_in;

   logic [stersu_pkg::CSR_W-1:0] first_cfg_ff, first_cfg_in;
   logic [stersu_pkg::CSR_W-1:0] last_cfg_ff, last_cfg_in;

   logic signed [stersu_pkg::IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [stersu_pkg::POS_W-1:0] mid_ff, mid_in;
   logic [stersu_pkg::POS_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [stersu_pkg::POS_W-1:0] blo_ff, blo_in, bhi_ff, bhi_in;
   logic signed [stersu_pkg::DATA_W-1:0] key_ff, key_in;
   logic hit_ff, hit_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [stersu_pkg::POS_W-1:0] rsp_first_ff, rsp_first_in;
   logic [stersu_pkg::POS_W-1:0] rsp_last_ff, rsp_last_in;
   logic [stersu_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic accept;
   logic ram_wr_en;
   logic [AW-1:0] ram_rd_addr;
   logic [stersu_pkg::DATA_W-1:0] ram_rd_data;
   logic signed [stersu_pkg::DATA_W-1:0] probe;
   logic probe_eq, probe_lt;
   logic signed [stersu_pkg::IDX_W-1:0] idx_sum;
   logic [stersu_pkg::POS_W-1:0] mid_calc;
   logic [stersu_pkg::POS_W-1:0] bhi_clamped;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Table write: drop positions beyond the table.
   assign ram_wr_en = accept && (req_action == stersu_pkg::ACTION_WRITE)
                      && (17'(req_position) < DEPTH_V);

   // Midpoint of a live range; lo and hi are both non-negative here.
   assign idx_sum  = lo_ff + hi_ff;
   assign mid_calc = idx_sum[stersu_pkg::POS_W:1];

   // Clamp the top of the range to the table.
   assign bhi_clamped = (17'(last_cfg_ff) > MAX_IDX_V)
                        ? stersu_pkg::POS_W'(TABLE_DEPTH - 1) : last_cfg_ff;

   // Shared compare unit: every probe and scan step goes through it.
   assign probe    = $signed(ram_rd_data);
   assign probe_eq = (probe == key_ff);
   assign probe_lt = (probe < key_ff);

   always_comb begin
      case (state_ff)
         S_LEFT:  ram_rd_addr = AW'(left_ff - 10'd1);
         S_RIGHT: ram_rd_addr = AW'(right_ff + 10'd1);
         default: ram_rd_addr = AW'(mid_calc);
      endcase
   end

   stersu_ram #(
      .WIDTH(stersu_pkg::DATA_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(AW'(req_position)),
      .wr_data(req_element_value),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      first_cfg_in = first_cfg_ff;
      last_cfg_in  = last_cfg_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      blo_in       = blo_ff;
      bhi_in       = bhi_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      // drop the result word once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;

      if (csr_wr_en) begin
         case (csr_index)
            stersu_pkg::CSR_SEARCH_FIRST: first_cfg_in = csr_data;
            stersu_pkg::CSR_SEARCH_LAST:  last_cfg_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == stersu_pkg::ACTION_QUERY)) begin
               key_in   = req_search_key;
               blo_in   = first_cfg_ff;
               bhi_in   = bhi_clamped;
               lo_in    = $signed({2'b00, first_cfg_ff});
               hi_in    = $signed({2'b00, bhi_clamped});
               hit_in   = 1'b0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // an empty range, or one narrowed to nothing, is a miss
            if (lo_ff > hi_ff) begin
               state_in = S_OUT;
            end else begin
               mid_in   = mid_calc;
               state_in = S_PCMP;
            end
         end
         S_PCMP: begin
            if (probe_eq) begin
               hit_in   = 1'b1;
               left_in  = mid_ff;
               right_in = mid_ff;
               state_in = S_LEFT;
            end else if (probe_lt) begin
               lo_in    = $signed({2'b00, mid_ff}) + 12'sd1;
               state_in = S_PROBE;
            end else begin
               hi_in    = $signed({2'b00, mid_ff}) - 12'sd1;
               state_in = S_PROBE;
            end
         end
         S_LEFT: begin
            // stop at the low bound of the range
            state_in = (left_ff > blo_ff) ? S_LCMP : S_RIGHT;
         end
         S_LCMP: begin
            if (probe_eq) begin
               left_in  = left_ff - 10'd1;
               state_in = S_LEFT;
            end else begin
               state_in = S_RIGHT;
            end
         end
         S_RIGHT: begin
            state_in = (right_ff < bhi_ff) ? S_RCMP : S_OUT;
         end
         S_RCMP: begin
            if (probe_eq) begin
               right_in = right_ff + 10'd1;
               state_in = S_RIGHT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               if (hit_ff) begin
                  rsp_first_in = left_ff;
                  rsp_last_in  = right_ff;
                  rsp_count_in = {1'b0, right_ff} - {1'b0, left_ff} + 11'd1;
               end else begin
                  rsp_first_in = '0;
                  rsp_last_in  = '0;
                  rsp_count_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_cfg_ff <= stersu_pkg::SEARCH_FIRST_RESET;
         last_cfg_ff  <= stersu_pkg::SEARCH_LAST_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_cfg_ff <= first_cfg_in;
         last_cfg_ff  <= last_cfg_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      blo_ff       <= blo_in;
      bhi_ff       <= bhi_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_first_position = rsp_first_ff;
   assign rsp_last_position  = rsp_last_ff;
   assign rsp_match_count    = rsp_count_ff;

endmodule

@@ dv/sorted_table_equal_range_search_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_unit_test
// Self-checking bench for the equal-range search unit. It loads sorted (and
// sometimes deliberately unsorted) tables, moves the search window across the
// table and fires lookups. A local model of the table and window predicts each
// lookup's found flag, bounds and count, and a checker compares every response
// word against the oldest prediction. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_unit_test;

   localparam int TABLE_DEPTH     = 1024;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 8;      // lets a trailing write word finish
   localparam int DRAIN_CYCLES    = 32;
   localparam int HOLD_CYCLES     = 300;    // long response hold-off
   localparam int RANDOM_WORDS    = 360;
   localparam int CYCLE_LIMIT     = 2_000_000;

   localparam logic signed [stersu_pkg::DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [stersu_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic                           found;
      logic [stersu_pkg::POS_W-1:0]   first_position;
      logic [stersu_pkg::POS_W-1:0]   last_position;
      logic [stersu_pkg::COUNT_W-1:0] match_count;
   } equal_range_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_action;
   logic [stersu_pkg::POS_W-1:0]          req_position;
   logic signed [stersu_pkg::DATA_W-1:0]  req_element_value;
   logic signed [stersu_pkg::DATA_W-1:0]  req_search_key;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic                                  rsp_found;
   logic [stersu_pkg::POS_W-1:0]          rsp_first_position;
   logic [stersu_pkg::POS_W-1:0]          rsp_last_position;
   logic [stersu_pkg::COUNT_W-1:0]        rsp_match_count;
   logic                                  csr_wr_en;
   logic [stersu_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [stersu_pkg::CSR_W-1:0]          csr_data;

   // Local copy of the table and the search window
   logic signed [stersu_pkg::DATA_W-1:0]  table_image [TABLE_DEPTH];
   int                                    window_first;
   int                                    window_last;

   equal_range_type           expected_ranges [$];
   int                        mismatch_count = 0;
   int                        words_sent = 0;
   longint                    cycle_count = 0;

   // Idle controls, flipped by the test tasks
   bit                        sender_idles = 1'b1;
   bit                        receiver_idles = 1'b1;
   bit                        hold_results = 1'b0;

   sorted_table_equal_range_search_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_element_value  (req_element_value),
      .req_search_key     (req_search_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_first_position (rsp_first_position),
      .rsp_last_position  (rsp_last_position),
      .rsp_match_count    (rsp_match_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_table_equal_range_search_unit_test: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Binary-search the window for the key, then widen the hit to the whole
   // run of equal entries without leaving the window. Any miss is all zeros.
   function automatic equal_range_type predict_equal_range(
         logic signed [stersu_pkg::DATA_W-1:0] key);
      equal_range_type result;
      int              lo_bound, hi_bound, lo, hi, mid, left, right;
      bit              hit;
      result   = '0;
      hit      = 1'b0;
      lo_bound = window_first;
      hi_bound = (window_last > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : window_last;
      if (lo_bound > hi_bound)
         return result;
      lo  = lo_bound;
      hi  = hi_bound;
      mid = lo;
      while (!hit && lo <= hi) begin
         mid = (lo + hi) / 2;
         if (table_image[mid] == key)
            hit = 1'b1;
         else if (table_image[mid] < key)
            lo = mid + 1;
         else
            hi = mid - 1;
      end
      if (!hit)
         return result;
      left  = mid;
      right = mid;
      while (left > lo_bound && table_image[left - 1] == key)
         left--;
      while (right < hi_bound && table_image[right + 1] == key)
         right++;
      result.found          = 1'b1;
      result.first_position = left[stersu_pkg::POS_W-1:0];
      result.last_position  = right[stersu_pkg::POS_W-1:0];
      result.match_count    = stersu_pkg::COUNT_W'(right - left + 1);
      return result;
   endfunction

   // Track every accepted request word: update the table or predict a lookup
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_action == stersu_pkg::ACTION_WRITE)
            table_image[req_position] = req_element_value;
         else
            expected_ranges.push_back(predict_equal_range(req_search_key));
      end
   end

   // Compare each accepted response word with the oldest prediction
   always @(posedge clock) begin : check_responses
      equal_range_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ranges.size() == 0) begin
            $error("response word with no lookup outstanding");
            mismatch_count++;
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               mismatch_count++;
            end
            if (rsp_first_position !== want.first_position) begin
               $error("first_position: expected %0d, got %0d",
                      want.first_position, rsp_first_position);
               mismatch_count++;
            end
            if (rsp_last_position !== want.last_position) begin
               $error("last_position: expected %0d, got %0d",
                      want.last_position, rsp_last_position);
               mismatch_count++;
            end
            if (rsp_match_count !== want.match_count) begin
               $error("match_count: expected %0d, got %0d",
                      want.match_count, rsp_match_count);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response-side stall: either a long hold-off on request, or short random
   // bursts while receiver idling is on. Count the hold-off here so that the
   // sender keeps pushing words into a full block meanwhile.
   // ------------------------------------------------------------------------
   initial begin : drive_response_stall
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_results = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request-side helpers
   // ------------------------------------------------------------------------

   // Offer one word and hold it until accepted. Leave valid high on return so
   // that back-to-back words need no extra edge.
   task automatic offer_word(input logic action,
                             input logic [stersu_pkg::POS_W-1:0] position,
                             input logic signed [stersu_pkg::DATA_W-1:0] element_value,
                             input logic signed [stersu_pkg::DATA_W-1:0] search_key);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= action;
      req_position      <= position;
      req_element_value <= element_value;
      req_search_key    <= search_key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Fill the unused payload fields with noise so every bit gets exercised
   task automatic send_write(input int position,
                             input logic signed [stersu_pkg::DATA_W-1:0] value);
      offer_word(stersu_pkg::ACTION_WRITE, position[stersu_pkg::POS_W-1:0], value,
                 $urandom);
   endtask

   task automatic send_query(input logic signed [stersu_pkg::DATA_W-1:0] key);
      offer_word(stersu_pkg::ACTION_QUERY, stersu_pkg::POS_W'($urandom), $urandom, key);
   endtask

   // Drop valid, let the last accepted word reach the predictor, wait out
   // every outstanding lookup, then let a trailing write settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Move the search window while the block is idle. Keep the write enable
   // high across both registers and drop it once at the end.
   task automatic set_search_range(input int first_index, input int last_index);
      wait_for_idle();
      csr_wr_en <= 1'b1;
      csr_index <= stersu_pkg::CSR_SEARCH_FIRST;
      csr_data  <= first_index[stersu_pkg::CSR_W-1:0];
      @(posedge clock);
      window_first = first_index;
      csr_index <= stersu_pkg::CSR_SEARCH_LAST;
      csr_data  <= last_index[stersu_pkg::CSR_W-1:0];
      @(posedge clock);
      window_last = last_index;
      csr_wr_en <= 1'b0;
   endtask

   // Write a nondecreasing run over [first_index, last_index]. Dense runs use a
   // tiny step so that long stretches of equal entries show up.
   task automatic load_sorted_run(input int first_index, input int last_index,
                                  input bit dense);
      longint stride, value;
      int     seed_value;
      stride = dense ? 64'sd4 : 64'sh1_0000_0000 / (last_index - first_index + 1);
      seed_value = $urandom;
      value = dense ? longint'(seed_value)
                    : -64'sd2147483648 + longint'($urandom) % stride;
      for (int p = first_index; p <= last_index; p++) begin
         if (p != first_index && $urandom_range(0, 2) >= (dense ? 2 : 1))
            value += 1 + longint'($urandom) % stride;
         if (value > 64'sd2147483647)
            value = 64'sd2147483647;
         send_write(p, value[stersu_pkg::DATA_W-1:0]);
      end
   endtask

   // Mostly keys present in the window, some off-by-one neighbors (usually
   // misses), and some fully random keys
   function automatic logic signed [stersu_pkg::DATA_W-1:0] pick_key();
      int                                   roll;
      logic signed [stersu_pkg::DATA_W-1:0] key;
      roll = $urandom_range(0, 19);
      if (window_first > window_last || roll < 5)
         return $urandom;
      key = table_image[$urandom_range(window_first, window_last)];
      if (roll < 8)
         key = key + 1;
      else if (roll < 10)
         key = key - 1;
      return key;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Small table with runs at both ends and in the middle; hits and misses
   task automatic test_hits_and_misses();
      set_search_range(0, 7);
      send_write(0, VALUE_MIN);
      send_write(1, VALUE_MIN);
      send_write(2, -5);
      send_write(3, 7);
      send_write(4, 7);
      send_write(5, 7);
      send_write(6, VALUE_MAX);
      send_write(7, VALUE_MAX);
      send_query(VALUE_MIN);
      send_query(7);
      send_query(VALUE_MAX);
      send_query(-5);
      send_query(0);
      send_query(-6);
   endtask

   // Equal entries just outside the window must not be counted
   task automatic test_scan_stops_at_range_bounds();
      set_search_range(1, 6);
      send_query(VALUE_MIN);
      send_query(VALUE_MAX);
      send_query(7);
   endtask

   // First index above last index: always a miss
   task automatic test_empty_range();
      set_search_range(6, 1);
      send_query(7);
   endtask

   // Break the ordering and check the search still follows its probe sequence
   task automatic test_unsorted_table();
      set_search_range(0, 7);
      send_write(3, VALUE_MAX);
      send_write(5, VALUE_MIN);
      send_query(7);
      send_query(VALUE_MIN);
      send_query(VALUE_MAX);
   endtask

   // Load the whole table in order; afterwards every entry has been written,
   // so any window may be searched
   task automatic test_full_table();
      set_search_range(0, TABLE_DEPTH - 1);
      load_sorted_run(0, TABLE_DEPTH - 1, 1'b0);
      repeat (60) send_query(pick_key());
   endtask

   // Window registers at their extreme values
   task automatic test_range_extremes();
      set_search_range(TABLE_DEPTH - 1, TABLE_DEPTH - 1);
      repeat (3) send_query(pick_key());
      send_query(table_image[TABLE_DEPTH - 1]);
      set_search_range(0, 0);
      send_query(table_image[0]);
      repeat (3) send_query(pick_key());
      set_search_range(TABLE_DEPTH - 1, 0);
      repeat (2) send_query(pick_key());
      set_search_range(0, TABLE_DEPTH - 1);
      repeat (3) send_query(pick_key());
   endtask

   // Hold responses off for a long stretch while lookups keep coming, so the
   // block fills up and stalls its request side
   task automatic test_result_backpressure();
      set_search_range(100, 131);
      load_sorted_run(100, 131, 1'b1);
      hold_results = 1'b1;
      repeat (8) send_query(pick_key());
      wait_for_idle();
   endtask

   // Random windows, mostly small, most reloaded in order and then searched;
   // some stray writes break the ordering. Calm the last quarter down.
   task automatic test_random_ranges();
      int start_count, first_index, last_index, span, roll;
      start_count = words_sent;
      while (words_sent - start_count < RANDOM_WORDS) begin
         if (words_sent - start_count > RANDOM_WORDS * 3 / 4) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end else begin
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
         end
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            first_index = $urandom_range(1, TABLE_DEPTH - 1);
            last_index  = $urandom_range(0, first_index - 1);
         end else if (roll == 1) begin
            first_index = $urandom_range(0, 40);
            last_index  = TABLE_DEPTH - 1 - $urandom_range(0, 40);
         end else begin
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 32);
            first_index = $urandom_range(0, TABLE_DEPTH - span);
            last_index  = first_index + span - 1;
         end
         set_search_range(first_index, last_index);
         // skip the reload on empty and very wide windows
         if (roll > 1)
            load_sorted_run(first_index, last_index, $urandom_range(0, 2) == 0);
         repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(0, 9) == 0)
               send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            else
               send_query(pick_key());
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= stersu_pkg::ACTION_WRITE;
      req_position      <= '0;
      req_element_value <= '0;
      req_search_key    <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= stersu_pkg::CSR_SEARCH_FIRST;
      csr_data          <= '0;
      window_first      = int'(stersu_pkg::SEARCH_FIRST_RESET);
      window_last       = int'(stersu_pkg::SEARCH_LAST_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hits_and_misses();
      test_scan_stops_at_range_bounds();
      test_empty_range();
      test_unsorted_table();
      test_full_table();
      test_range_extremes();
      test_result_backpressure();
      test_random_ranges();

      // Drain, then give any stray response time to show up
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("sorted_table_equal_range_search_unit_test: clean");
      else
         $display("sorted_table_equal_range_search_unit_test: errors");
      $finish;
   end

endmodule
